// ===== hw/rtl/glob_wildcard_matcher_unit_macros.svh =====
// assertion macros for the glob wildcard matcher checker
// used by gwm_checker, no other dependencies
`ifndef GLOB_WILDCARD_MATCHER_UNIT_MACROS_SVH
`define GLOB_WILDCARD_MATCHER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define GWM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gwm check failed");

// next-cycle implication, disabled during reset
`define GWM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gwm check failed");

`endif

// ===== hw/rtl/gwm_pkg.sv =====
// shared types, constants and helpers of the glob wildcard matcher
// no dependencies
`default_nettype none

package gwm_pkg;

    localparam int MAX_PATTERN_DEF = 32;

    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] ANY_CHAR  = 8'h3F;
    localparam logic [7:0] UPPER_A   = 8'h41;
    localparam logic [7:0] UPPER_Z   = 8'h5A;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    typedef enum logic [1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_SOURCE = 2'd2,
        REQ_END    = 2'd3
    } req_t;

    // link between neighbouring cells
    typedef struct packed {
        logic occ;   // left position holds a pattern byte
        logic star;  // left position holds a star
        logic cl;    // closure across a star into this position
        logic fwd;   // left position consumes the source byte into this one
    } gwm_link_t;

    // controls broadcast to every cell
    typedef struct packed {
        logic       restart;
        logic       step;
        logic       clear;
        logic       append_ok;
        logic [7:0] wr_char;
        logic       wr_star;
        logic [7:0] src_fold;
        logic       match_case;
    } gwm_ctl_t;

    function automatic logic [7:0] fold_char(input logic [7:0] c, input logic mc);
        logic [7:0] r;
        r = c;
        if (!mc && c >= UPPER_A && c <= UPPER_Z)
        begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/glob_wildcard_matcher_unit.sv =====
// glob wildcard matcher: top level, request decode, cell chain and result register
// depends on gwm_pkg and gwm_cell
//
// usage
//  - input channel (in_valid/in_ready, req_type, char_code) carries one request per
//    transfer: clear pattern, append pattern byte, source byte, end of source
//  - output channel (out_valid/out_ready, matched, pattern_overflow) carries one
//    result for every end-of-source request, in order
//  - cfg channel (cfg_valid/cfg_ready, cfg_data) writes match_case; always ready;
//    the user writes it only while the block is idle; the block does not enforce this
//  - throughput: one request per cycle while in_ready is high; every source byte updates all pattern
//    positions at once in a row of cells, each handing its token to its neighbour
//  - result: the output register takes the result on the end-of-source
//    transfer
//  - in_ready stays high while the output register is empty or is being emptied in
//    the same cycle; a stalled result with out_ready low holds in_ready low
//  - consecutive stars are stored as one; the raw byte count still sets the
//    overflow point
//  - reset: empty pattern, no overflow, match_case 1, source at its start, output
//    empty; no clearing pass is needed
`default_nettype none

module glob_wildcard_matcher_unit #(
    parameter int MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // request channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] req_type,
    input  wire logic [7:0] char_code,
    // result channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            matched,
    output logic            pattern_overflow,
    // configuration channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);
    import gwm_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    // handshake
    logic in_fire;
    req_t req;

    // request decode
    logic is_clear, is_append, is_source, is_end;

    // state
    logic             match_case_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;      // raw pattern bytes taken
    logic             ovf_reg, ovf_next;
    logic             fresh_reg, fresh_next;  // source at its start
    logic             tail_reg, tail_next;    // active bit of the final position
    logic             out_valid_reg;
    logic             matched_reg;
    logic             pat_ovf_reg;

    // chain
    gwm_ctl_t             ctl;
    gwm_link_t            links [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] end_hits;
    logic                 tail_eff;
    logic                 tail_hit;
    logic                 accept_now;
    logic                 room;

    assign in_ready  = ~out_valid_reg | out_ready;
    assign in_fire   = in_valid & in_ready;
    assign cfg_ready = 1'b1;

    assign req = req_t'(req_type);

    always_comb
    begin
        is_clear  = 1'b0;
        is_append = 1'b0;
        is_source = 1'b0;
        is_end    = 1'b0;
        unique case (req)
            REQ_CLEAR:  is_clear  = in_fire;
            REQ_APPEND: is_append = in_fire;
            REQ_SOURCE: is_source = in_fire;
            REQ_END:    is_end    = in_fire;
            default:    is_end    = 1'b0;
        endcase
    end

    assign room = (cnt_reg != CNT_W'(MAX_PATTERN));

    // broadcast controls
    always_comb
    begin
        ctl.restart    = is_clear | is_append | is_end;
        ctl.step       = is_source;
        ctl.clear      = is_clear;
        ctl.append_ok  = is_append & room;
        ctl.wr_char    = char_code;
        ctl.wr_star    = (char_code == STAR_CHAR);
        ctl.src_fold   = fold_char(char_code, match_case_reg);
        ctl.match_case = match_case_reg;
    end

    // start of chain: position 0 is active while the source is fresh
    assign links[0].occ  = 1'b1;
    assign links[0].star = 1'b0;
    assign links[0].cl   = fresh_reg;
    assign links[0].fwd  = 1'b0;

    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_cell
        gwm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .link_in  (links[i]),
            .link_out (links[i+1]),
            .end_hit  (end_hits[i])
        );
    end

    // final position beyond the store, reached only when the store is full
    assign tail_eff = tail_reg | links[MAX_PATTERN].cl;
    assign tail_hit = tail_eff & links[MAX_PATTERN].occ;

    // exactly one position is the end of the pattern
    assign accept_now = (|end_hits) | tail_hit;

    always_comb
    begin
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        fresh_next = fresh_reg;
        tail_next  = tail_reg;
        if (is_clear)
        begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
        else if (is_append)
        begin
            if (room)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        if (ctl.restart)
        begin
            fresh_next = 1'b1;
            tail_next  = 1'b0;
        end
        else if (ctl.step)
        begin
            fresh_next = 1'b0;
            tail_next  = links[MAX_PATTERN].fwd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_case_reg <= 1'b1;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            fresh_reg      <= 1'b1;
            tail_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                match_case_reg <= cfg_data;
            end
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            fresh_reg <= fresh_next;
            tail_reg  <= tail_next;
            if (is_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (is_end)
        begin
            matched_reg <= accept_now;
            pat_ovf_reg <= ovf_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = pat_ovf_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/gwm_cell.sv =====
// one pattern position of the matcher chain: byte, occupancy and active bit
// depends on gwm_pkg
`default_nettype none

module gwm_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire gwm_pkg::gwm_ctl_t ctl,
    input  wire gwm_pkg::gwm_link_t link_in,
    output gwm_pkg::gwm_link_t     link_out,
    output logic                   end_hit
);
    import gwm_pkg::*;

    logic       occ_reg, occ_next;
    logic       act_reg, act_next;
    logic [7:0] char_reg;
    logic       eff;
    logic       is_star;
    logic       hit;
    logic       wr;

    assign eff     = act_reg | link_in.cl;
    assign is_star = (char_reg == STAR_CHAR);
    assign hit     = (char_reg == ANY_CHAR) ||
                     (fold_char(char_reg, ctl.match_case) == ctl.src_fold);

    // first free slot takes the byte, a star after a star is folded away
    assign wr = ctl.append_ok & ~occ_reg & link_in.occ & ~(ctl.wr_star & link_in.star);

    assign link_out.occ  = occ_reg;
    assign link_out.star = occ_reg & is_star;
    assign link_out.cl   = eff & occ_reg & is_star;
    assign link_out.fwd  = eff & occ_reg & ~is_star & hit;

    assign end_hit = eff & ~occ_reg & link_in.occ;

    always_comb
    begin
        occ_next = occ_reg;
        if (ctl.clear)
        begin
            occ_next = 1'b0;
        end
        else if (wr)
        begin
            occ_next = 1'b1;
        end
    end

    always_comb
    begin
        act_next = act_reg;
        if (ctl.restart)
        begin
            act_next = 1'b0;
        end
        else if (ctl.step)
        begin
            act_next = (eff & occ_reg & is_star) | link_in.fwd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            act_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            act_reg <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            char_reg <= ctl.wr_char;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gwm_checker.sv =====
// port-level checks of the glob wildcard matcher, bound to the top level
// depends on gwm_pkg and glob_wildcard_matcher_unit_macros.svh
`default_nettype none
`include "glob_wildcard_matcher_unit_macros.svh"

module gwm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic [1:0] req_type,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic       matched,
    input wire logic       pattern_overflow
);
    import gwm_pkg::*;

    // input only stalls behind a stalled result
    `GWM_ASSERT_NOW(a_ready_only_stalled, clk, rst_n, !in_ready, out_valid && !out_ready)

    // an end-of-source transfer always yields a result next cycle
    `GWM_ASSERT_NEXT(a_end_gives_result, clk, rst_n,
        in_valid && in_ready && req_type == REQ_END, out_valid)

    // a stalled result keeps its payload
    `GWM_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(matched) && $stable(pattern_overflow))

    // a clear directly followed by an end reports no overflow and a match
    `GWM_ASSERT_NEXT(a_clear_then_end, clk, rst_n,
        (in_valid && in_ready && req_type == REQ_CLEAR) ##1
        (in_valid && in_ready && req_type == REQ_END),
        !pattern_overflow && matched)

endmodule

bind glob_wildcard_matcher_unit gwm_checker u_gwm_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for glob_wildcard_matcher_unit: directed and random glob traffic
// depends on gwm_pkg and the matcher rtl; a predictor of its own forms the expected results
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gwm_pkg::*;

    localparam int PAT_DEPTH = gwm_pkg::MAX_PATTERN_DEF;

    typedef logic [PAT_DEPTH:0] pos_set_t;

    // one end-of-source verdict as the block should give it
    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] req_type = REQ_CLEAR;
    logic [7:0] char_code = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       matched;
    logic       pattern_overflow;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b1;

    // predictor state: stored glob, live pattern positions, overflow, case mode
    logic [7:0]  glob_bytes [PAT_DEPTH];
    int unsigned glob_len;
    pos_set_t    live_pos;
    logic        glob_ovf;
    logic        exact_case;

    verdict_t    verdicts_due [$];
    logic [7:0]  src_buf [$];
    int unsigned items_sent;
    int unsigned mismatch_count;
    logic        steady;

    glob_wildcard_matcher_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .char_code        (char_code),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .matched          (matched),
        .pattern_overflow (pattern_overflow),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // byte as compared: upper-case letters fold down when case is ignored
    function automatic logic [7:0] case_key(input logic [7:0] c);
        if (!exact_case && c >= UPPER_A && c <= UPPER_Z)
        begin
            return c - UPPER_A + 8'h61;
        end
        return c;
    endfunction

    // a live star lets the position after it be live too, chains of stars included
    function automatic pos_set_t across_stars(input pos_set_t v);
        pos_set_t r;
        r = v;
        for (int p = 0; p < glob_len; p++)
        begin
            if (r[p] && glob_bytes[p] == STAR_CHAR)
            begin
                r[p + 1] = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void restart_source();
        live_pos = across_stars(pos_set_t'(1));
    endfunction

    // every live position moves on together for one source byte
    function automatic void consume_byte(input logic [7:0] c);
        pos_set_t   nxt;
        logic [7:0] pc;
        nxt = '0;
        for (int p = 0; p < glob_len; p++)
        begin
            if (live_pos[p])
            begin
                pc = glob_bytes[p];
                if (pc == STAR_CHAR)
                begin
                    nxt[p] = 1'b1;
                end
                else if (pc == ANY_CHAR || case_key(pc) == case_key(c))
                begin
                    nxt[p + 1] = 1'b1;
                end
            end
        end
        live_pos = across_stars(nxt);
    endfunction

    function automatic void glob_reset();
        glob_len   = 0;
        glob_ovf   = 1'b0;
        exact_case = 1'b1;
        restart_source();
    endfunction

    // apply one accepted request; an end of source queues its verdict
    function automatic void glob_predict(input req_t req, input logic [7:0] c);
        verdict_t v;
        case (req)
            REQ_CLEAR:
            begin
                glob_len = 0;
                glob_ovf = 1'b0;
                restart_source();
            end
            REQ_APPEND:
            begin
                if (glob_len < PAT_DEPTH)
                begin
                    glob_bytes[glob_len] = c;
                    glob_len++;
                end
                else
                begin
                    glob_ovf = 1'b1;
                end
                restart_source();
            end
            REQ_SOURCE:
            begin
                consume_byte(c);
            end
            default:
            begin
                v.matched  = live_pos[glob_len];
                v.overflow = glob_ovf;
                verdicts_due.push_back(v);
                restart_source();
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < 200)
        begin
            $display("mismatch at %0t ns: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // handshake signals only change on the rising edge, so the falling edge
    // sees exactly what the next rising edge will take as a transfer
    always @(negedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                flag_mismatch("result transfer with no result outstanding");
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (matched !== want.matched)
                begin
                    flag_mismatch($sformatf("matched %b, predicted %b",
                                            matched, want.matched));
                end
                if (pattern_overflow !== want.overflow)
                begin
                    flag_mismatch($sformatf("pattern_overflow %b, predicted %b",
                                            pattern_overflow, want.overflow));
                end
            end
        end
    end

    // result side back-pressure: out_ready drawn low about 28 times in 100, never while steady
    always @(posedge clk)
    begin
        if (steady)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= 28);
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    // one request transfer; called and returning on a rising edge
    task automatic send_item(input req_t req, input logic [7:0] c);
        // a gap now and then, which lands on whatever phase the block is in
        if (!steady && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= req;
        char_code <= c;
        @(negedge clk);
        while (!in_ready)
        begin
            @(negedge clk);
        end
        // the transfer happens on the coming rising edge
        glob_predict(req, c);
        items_sent++;
        @(posedge clk);
    endtask

    // stop requests, let every verdict come out, then wait for requests
    // that give no result to finish inside the block
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // match_case write; only ever called with the block idle
    task automatic write_match_case(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(negedge clk);
        while (!cfg_ready)
        begin
            @(negedge clk);
        end
        exact_case = v;
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // bytes that make interesting globs and text: letters in both cases,
    // the two wildcards, and now and then anything at all
    function automatic logic [7:0] text_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h61;   // a
            1:       return 8'h62;   // b
            2:       return UPPER_A;
            3:       return 8'h42;   // B
            4:       return STAR_CHAR;
            5:       return ANY_CHAR;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == STAR_CHAR || c == ANY_CHAR)
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // source text built from the stored glob so that most of it matches;
    // letters swap case now and then and some strings get one byte spoilt
    function automatic void make_source();
        logic [7:0]  pc;
        int unsigned at;
        src_buf.delete();
        for (int p = 0; p < glob_len; p++)
        begin
            pc = glob_bytes[p];
            if (pc == STAR_CHAR)
            begin
                if (p == 0 || glob_bytes[p - 1] != STAR_CHAR)
                begin
                    repeat ($urandom_range(0, 3)) src_buf.push_back(text_byte());
                end
            end
            else if (pc == ANY_CHAR)
            begin
                src_buf.push_back(8'($urandom_range(0, 255)));
            end
            else if (pc >= UPPER_A && pc <= UPPER_Z && $urandom_range(99) < 30)
            begin
                src_buf.push_back(pc + 8'h20);
            end
            else if (pc >= 8'h61 && pc <= 8'h7A && $urandom_range(99) < 30)
            begin
                src_buf.push_back(pc - 8'h20);
            end
            else
            begin
                src_buf.push_back(pc);
            end
        end
        if ($urandom_range(99) < 30)
        begin
            at = $urandom_range(0, src_buf.size());
            case ($urandom_range(0, 2))
                0:
                begin
                    src_buf.insert(at, text_byte());
                end
                1:
                begin
                    if (at < src_buf.size())
                    begin
                        src_buf.delete(at);
                    end
                end
                default:
                begin
                    if (at < src_buf.size())
                    begin
                        src_buf[at] = src_buf[at] ^ (8'h01 << $urandom_range(0, 7));
                    end
                end
            endcase
        end
    endfunction

    // clear (usually), load a glob, then one to three source strings
    task automatic run_glob_sequence();
        int unsigned plen;
        int unsigned pick;
        if ($urandom_range(99) < 85)
        begin
            send_item(REQ_CLEAR, 8'($urandom_range(0, 255)));
        end
        pick = $urandom_range(99);
        if (pick < 85)
        begin
            plen = $urandom_range(0, 8);
        end
        else if (pick < 95)
        begin
            plen = $urandom_range(9, 31);
        end
        else
        begin
            // runs up to or past the store so that bytes may get dropped
            plen = $urandom_range(32, 35);
        end
        repeat (plen) send_item(REQ_APPEND, text_byte());
        repeat ($urandom_range(1, 3))
        begin
            make_source();
            foreach (src_buf[i])
            begin
                send_item(REQ_SOURCE, src_buf[i]);
            end
            send_item(REQ_END, 8'($urandom_range(0, 255)));
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // empty globs, star-only globs, wildcards, byte extremes, exact case
    task automatic test_basics();
        send_item(REQ_END, 8'h00);             // empty glob, empty source
        send_item(REQ_SOURCE, 8'h00);          // byte zero is ordinary text
        send_item(REQ_END, 8'h00);             // empty glob, non-empty source
        send_item(REQ_APPEND, STAR_CHAR);
        send_item(REQ_APPEND, STAR_CHAR);
        send_item(REQ_END, 8'hFF);             // stars only, empty source
        send_item(REQ_APPEND, 8'hFF);
        send_item(REQ_APPEND, ANY_CHAR);
        send_item(REQ_APPEND, 8'h00);
        send_item(REQ_SOURCE, 8'h11);
        send_item(REQ_SOURCE, 8'hFF);
        send_item(REQ_SOURCE, 8'h7E);
        send_item(REQ_SOURCE, 8'h00);
        send_item(REQ_END, 8'h55);
        send_item(REQ_CLEAR, 8'hFF);           // byte ignored on clear
        send_item(REQ_END, 8'hAA);
        send_item(REQ_APPEND, UPPER_A);
        send_item(REQ_APPEND, 8'h7A);          // z
        send_item(REQ_SOURCE, 8'h61);          // a
        send_item(REQ_SOURCE, UPPER_Z);
        send_item(REQ_END, 8'h00);             // no match while case is exact
    endtask

    // case folding on both sides, the letter range edges, and a mode change
    // in the middle of a source string
    task automatic test_case_fold();
        settle_idle();
        write_match_case(1'b0);
        send_item(REQ_SOURCE, 8'h61);          // a against A
        send_item(REQ_SOURCE, UPPER_Z);        // Z against z
        send_item(REQ_END, 8'h00);
        send_item(REQ_CLEAR, 8'h00);
        send_item(REQ_APPEND, UPPER_A - 8'h01);  // just below the letters
        send_item(REQ_APPEND, UPPER_Z + 8'h01);  // just above
        send_item(REQ_SOURCE, 8'h60);
        send_item(REQ_SOURCE, 8'h7B);
        send_item(REQ_END, 8'h00);
        send_item(REQ_SOURCE, UPPER_A - 8'h01);
        send_item(REQ_SOURCE, UPPER_Z + 8'h01);
        send_item(REQ_END, 8'h00);
        send_item(REQ_CLEAR, 8'h00);
        send_item(REQ_APPEND, 8'h51);          // Q
        send_item(REQ_APPEND, 8'h71);          // q
        send_item(REQ_SOURCE, 8'h71);
        settle_idle();
        write_match_case(1'b1);
        send_item(REQ_SOURCE, 8'h51);
        send_item(REQ_END, 8'h00);
        settle_idle();
        write_match_case(1'b0);
        send_item(REQ_SOURCE, 8'h71);
        send_item(REQ_SOURCE, 8'h51);
        send_item(REQ_END, 8'h00);
    endtask

    // full store, dropped bytes, the sticky flag, and clear taking it away
    task automatic test_pattern_overflow();
        send_item(REQ_CLEAR, 8'h00);
        for (int i = 0; i < PAT_DEPTH; i++)
        begin
            send_item(REQ_APPEND, plain_byte());
        end
        for (int i = 0; i < PAT_DEPTH; i++)
        begin
            send_item(REQ_SOURCE, glob_bytes[i]);
        end
        send_item(REQ_END, 8'h00);             // full, not yet overflowed
        send_item(REQ_APPEND, 8'h61);
        send_item(REQ_APPEND, STAR_CHAR);
        for (int i = 0; i < PAT_DEPTH; i++)
        begin
            send_item(REQ_SOURCE, glob_bytes[i]);
        end
        send_item(REQ_END, 8'h00);             // dropped bytes do not take part
        send_item(REQ_END, 8'h00);             // empty source, flag still set
        send_item(REQ_CLEAR, 8'h00);
        send_item(REQ_END, 8'h00);
    endtask

    // mostly well-formed glob and source sequences, some raw noise, a change
    // of case mode every so often and one stretch with no idling on either side
    task automatic test_random_globs();
        int unsigned stop_at;
        int unsigned next_cfg;
        int unsigned quiet_from;
        stop_at    = items_sent + 950;
        next_cfg   = items_sent + 150;
        quiet_from = items_sent + 400;
        while (items_sent < stop_at)
        begin
            steady = (items_sent >= quiet_from && items_sent < quiet_from + 200);
            if (items_sent >= next_cfg)
            begin
                settle_idle();
                write_match_case(($urandom_range(99) < 60) ? ~exact_case : exact_case);
                next_cfg = items_sent + $urandom_range(100, 200);
            end
            if ($urandom_range(99) < 12)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_item(req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                run_glob_sequence();
            end
        end
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // run
    // ---------------------------------------------------------------

    initial
    begin
        int unsigned spin;
        items_sent     = 0;
        mismatch_count = 0;
        steady         = 1'b0;
        glob_reset();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basics();
        test_case_fold();
        test_pattern_overflow();
        test_random_globs();

        // drain: wait for outstanding verdicts, bounded, then a short tail
        in_valid <= 1'b0;
        spin = 0;
        while (verdicts_due.size() != 0 && spin < 5000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (5) @(posedge clk);
        if (verdicts_due.size() != 0)
        begin
            flag_mismatch($sformatf("%0d results never transferred", verdicts_due.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
